FILE: hdl/bary_pkg.sv
// Package for the barycentric inside test: constants and pipeline side-band types.
package bary_pkg;

  localparam int COORD_BITS_DEF = 13;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int PIX_BITS       = 12;
  localparam int MARGIN_BITS    = 16;
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 16'd7;

  // number of sub-triangles (one per weight)
  localparam int NUM_WEIGHTS = 3;

  // side-band travelling alongside the divider stages
  typedef struct packed {
    logic                   valid;
    logic                   degen;
    logic [NUM_WEIGHTS-1:0] neg;
    logic [NUM_WEIGHTS-1:0] ovf;
  } bary_meta_t;

endpackage

FILE: hdl/bary_div.sv
// Pipelined restoring divider: one quotient bit per register stage.
module bary_div #(
  parameter int MW = 30,
  parameter int QW = 20
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] num,
  input  logic [MW-1:0] den,
  output logic [QW-1:0] quo
);
  import bary_pkg::*;

  // remainder stays below the scaled divisor (den * 8) as long as num is below it
  logic [MW+2:0] rem  [QW];
  logic [MW+2:0] dvs  [QW];
  logic [QW-1:0] qt   [QW];

  logic [MW+2:0] rem_next [QW];
  logic [MW+2:0] dvs_next [QW];
  logic [QW-1:0] qt_next  [QW];

  // one compare-subtract per stage
  always_comb begin
    logic [MW+2:0] r_in;
    logic [MW+2:0] b_in;
    logic [QW-1:0] q_in;
    logic [MW+3:0] two;
    logic [MW+3:0] diff;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        r_in = {3'b000, num};
        b_in = {den, 3'b000};
        q_in = '0;
      end else begin
        r_in = rem[i-1];
        b_in = dvs[i-1];
        q_in = qt[i-1];
      end
      two  = {r_in, 1'b0};
      diff = two - {1'b0, b_in};
      if (two >= {1'b0, b_in}) begin
        rem_next[i] = diff[MW+2:0];
        qt_next[i]  = {q_in[QW-2:0], 1'b1};
      end else begin
        rem_next[i] = two[MW+2:0];
        qt_next[i]  = {q_in[QW-2:0], 1'b0};
      end
      dvs_next[i] = b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        rem[i] <= rem_next[i];
        dvs[i] <= dvs_next[i];
        qt[i]  <= qt_next[i];
      end
    end
  end

  assign quo = qt[QW-1];

endmodule

FILE: hdl/barycentric_inside_test_top.sv
// Top level of the barycentric point-in-triangle test pipeline.
// One beat in, one beat out: a new triangle/pixel beat may enter every clock and the
// result passes through one stage of edge products, one of area sums, one of
// magnitudes, one of range checks, one divider stage per quotient bit (FRAC_BITS+4),
// and one stage of rounding, clamping and the inside compare. The whole pipeline
// holds while a finished result waits to be taken. Weights are signed Q2.FRAC_BITS,
// rounded to nearest (ties away from zero) and clamped; a zero-area triangle gives
// degenerate=1, zero weights and outside. inside_margin (reset 7) is written through
// cfg_wr_en/cfg_wr_data; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module barycentric_inside_test_top #(
  parameter int COORD_BITS = bary_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bary_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  // config
  input  logic                            cfg_wr_en,
  input  logic [bary_pkg::MARGIN_BITS-1:0] cfg_wr_data,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, pixel_x, pixel_y
  input  logic [((6*COORD_BITS+2*bary_pkg::PIX_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // inside_res, degenerate, weight_alpha, weight_beta, weight_gamma
  output logic [((2+3*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  import bary_pkg::*;

  localparam int EW   = (COORD_BITS > PIX_BITS + 1) ? COORD_BITS : PIX_BITS + 1;
  localparam int DFW  = EW + 1;
  localparam int PW   = EW + DFW;
  localparam int AW   = PW + 2;
  localparam int QW   = FRAC_BITS + 4;
  localparam int WB   = FRAC_BITS + 2;
  localparam int CMPW = ((WB > MARGIN_BITS + 1) ? WB : MARGIN_BITS + 1) + 1;
  localparam int OUTW = 2 + 3 * WB;
  localparam logic [QW-1:0] MAXP = QW'((64'd1 << (WB - 1)) - 64'd1);

  logic                   adv;
  logic [MARGIN_BITS-1:0] inside_margin;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_margin <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      inside_margin <= cfg_wr_data;
    end
  end

  // whole pipeline moves when the output slot is free or being drained
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // unpack and extend the points: a, b, c, pixel
  logic signed [EW-1:0] ptx [4];
  logic signed [EW-1:0] pty [4];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      ptx[v] = EW'($signed(s_axis_tdata[(2*v)*COORD_BITS +: COORD_BITS]));
      pty[v] = EW'($signed(s_axis_tdata[(2*v+1)*COORD_BITS +: COORD_BITS]));
    end
    ptx[3] = EW'($signed({1'b0, s_axis_tdata[6*COORD_BITS +: PIX_BITS]}));
    pty[3] = EW'($signed({1'b0, s_axis_tdata[6*COORD_BITS+PIX_BITS +: PIX_BITS]}));
  end

  // stage 1: edge products; triangle 0 is abc, 1 puts p for b, 2 for c, 3 for a
  logic signed [PW-1:0] prod      [4][3];
  logic signed [PW-1:0] prod_next [4][3];
  logic                 v1;

  always_comb begin
    int i0;
    int i1;
    int i2;
    logic signed [DFW-1:0] df;
    for (int t = 0; t < 4; t++) begin
      for (int k = 0; k < 3; k++) begin
        i0 = (t != 0 && k == (t % 3)) ? 3 : k;
        i1 = (t != 0 && ((k + 1) % 3) == (t % 3)) ? 3 : (k + 1) % 3;
        i2 = (t != 0 && ((k + 2) % 3) == (t % 3)) ? 3 : (k + 2) % 3;
        df = DFW'(pty[i1]) - DFW'(pty[i2]);
        prod_next[t][k] = PW'(ptx[i0]) * PW'(df);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
    end
    if (adv) begin
      prod <= prod_next;
    end
  end

  // stage 2: doubled areas
  logic signed [AW-1:0] area [4];
  logic                 v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      for (int t = 0; t < 4; t++) begin
        area[t] <= AW'(prod[t][0]) + AW'(prod[t][1]) + AW'(prod[t][2]);
      end
    end
  end

  // stage 3: magnitudes, quotient signs, zero-area flag
  logic [AW-1:0]          mag [4];
  logic [NUM_WEIGHTS-1:0] neg3;
  logic                   degen3;
  logic                   v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int t = 0; t < 4; t++) begin
        mag[t] <= area[t][AW-1] ? AW'(-area[t]) : AW'(area[t]);
      end
      for (int w = 0; w < NUM_WEIGHTS; w++) begin
        neg3[w] <= area[w+1][AW-1] ^ area[0][AW-1];
      end
      degen3 <= (area[0] == '0);
    end
  end

  // stage 4: quotient overflow when sub-area >= 8 * area
  logic [AW-1:0] num4 [NUM_WEIGHTS];
  logic [AW-1:0] den4;
  bary_meta_t    meta4;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta4.valid <= 1'b0;
    end else if (adv) begin
      meta4.valid <= v3;
    end
    if (adv) begin
      for (int w = 0; w < NUM_WEIGHTS; w++) begin
        num4[w]      <= mag[w+1];
        meta4.ovf[w] <= {3'b000, mag[w+1]} >= {mag[0], 3'b000};
      end
      den4        <= mag[0];
      meta4.neg   <= neg3;
      meta4.degen <= degen3;
    end
  end

  // dividers, one per weight
  logic [QW-1:0] quo [NUM_WEIGHTS];

  for (genvar w = 0; w < NUM_WEIGHTS; w++) begin : g_div
    bary_div #(
      .MW(AW),
      .QW(QW)
    ) u_div (
      .clk(clk),
      .en (adv),
      .num(num4[w]),
      .den(den4),
      .quo(quo[w])
    );
  end

  // side-band delay line matching the divider
  bary_meta_t mpipe [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        mpipe[i].valid <= 1'b0;
      end
    end else if (adv) begin
      mpipe[0].valid <= meta4.valid;
      for (int i = 1; i < QW; i++) begin
        mpipe[i].valid <= mpipe[i-1].valid;
      end
    end
    if (adv) begin
      mpipe[0].degen <= meta4.degen;
      mpipe[0].neg   <= meta4.neg;
      mpipe[0].ovf   <= meta4.ovf;
      for (int i = 1; i < QW; i++) begin
        mpipe[i].degen <= mpipe[i-1].degen;
        mpipe[i].neg   <= mpipe[i-1].neg;
        mpipe[i].ovf   <= mpipe[i-1].ovf;
      end
    end
  end

  // final stage: round, clamp, sign, inside compare
  bary_meta_t          mo;
  logic signed [WB-1:0] wt_next [NUM_WEIGHTS];
  logic                 in_next;

  assign mo = mpipe[QW-1];

  always_comb begin
    logic [QW:0]           qr;
    logic [QW-1:0]         qm;
    logic signed [CMPW-1:0] sum;
    in_next = !mo.degen;
    for (int w = 0; w < NUM_WEIGHTS; w++) begin
      qr = ({1'b0, quo[w]} + 1'b1) >> 1;
      qm = qr[QW-1:0];
      if (mo.degen) begin
        wt_next[w] = '0;
      end else if (mo.neg[w]) begin
        if (mo.ovf[w] || qm > MAXP + 1'b1) begin
          wt_next[w] = WB'(-(MAXP + 1'b1));
        end else begin
          wt_next[w] = WB'(-qm);
        end
      end else begin
        if (mo.ovf[w] || qm > MAXP) begin
          wt_next[w] = WB'(MAXP);
        end else begin
          wt_next[w] = WB'(qm);
        end
      end
      sum = CMPW'(wt_next[w]) + $signed(CMPW'(inside_margin));
      if (sum <= 0) begin
        in_next = 1'b0;
      end
    end
  end

  logic                 inside_res;
  logic                 degenerate;
  logic signed [WB-1:0] wt [NUM_WEIGHTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= mo.valid;
    end
    if (adv) begin
      inside_res <= in_next;
      degenerate <= mo.degen;
      wt         <= wt_next;
    end
  end

  // output packing, zero padded to whole bytes
  always_comb begin
    m_axis_tdata           = '0;
    m_axis_tdata[OUTW-1:0] = {wt[2], wt[1], wt[0], degenerate, inside_res};
  end

  // a zero-area result carries zero weights and is never inside
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && degenerate |-> !inside_res && wt[0] == '0 && wt[1] == '0 && wt[2] == '0)
    else $error("degenerate result with non-zero weights or inside set");

  // an accepted beat shows up as a valid entry in the product stage
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> v1)
    else $error("accepted beat lost at product stage");

  // a held stage keeps its valid bit through a stall
  assert property (@(posedge clk) disable iff (rst)
    !adv && mo.valid |=> mo.valid)
    else $error("divider output stage dropped during stall");

  // inside is never reported for a zero-area triangle; inside also needs every weight above minus the margin
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && inside_res |-> !degenerate)
    else $error("inside reported for zero-area triangle");

endmodule
